FILE: rtl/core/drp_pkg.sv
// Shared types, codes and constants of the DNS A-record response parser.
package drp_pkg;

    localparam int unsigned HEADER_LAST_IDX = 11;
    localparam int unsigned ANSWER_FIXED_BYTES = 10;
    localparam int unsigned QUESTION_FIXED_BYTES = 4;
    localparam logic [7:0] PTR_MASK = 8'hC0;
    localparam logic [15:0] A_TYPE = 16'd1;
    localparam logic [15:0] A_LEN = 16'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd3;
    localparam logic [2:0] ST_RCODE = 3'd4;
    localparam logic [2:0] ST_NO_ANSWERS = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;
    localparam logic [2:0] ST_NO_A = 3'd7;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_LABEL  = 4'd2,
        PH_PTR    = 4'd3,
        PH_QFIXED = 4'd4,
        PH_AFIXED = 4'd5,
        PH_RDATA  = 4'd6,
        PH_DONE   = 4'd7,
        PH_HALT   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ip;
    } result_t;

endpackage

FILE: rtl/core/drp_in_stage.sv
// Input register of the parser: holds one message byte until it is consumed.
module drp_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              out_room,
    output logic              consume,
    output drp_pkg::in_item_t item
);

    logic              vld_reg;
    logic              vld_next;
    drp_pkg::in_item_t item_reg;
    logic              accept;

    // a final byte needs a free result slot; any other byte goes at once
    assign consume  = vld_reg & (~item_reg.last | out_room);
    assign in_stall = vld_reg & ~consume;
    assign accept   = in_valid & ~in_stall;
    assign vld_next = accept | (vld_reg & ~consume);
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= last_byte;
        end
    end

endmodule

FILE: rtl/core/drp_parser.sv
// Parse state machine: walks header, questions and answers one byte per cycle, advancing only on a consumed byte.
module drp_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      expected_id,
    input  logic             consume,
    input  drp_pkg::in_item_t item,
    output logic             res_fire,
    output drp_pkg::result_t result
);

    drp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [15:0] header_word_reg, header_word_next;
    logic [15:0] questions_left_reg, questions_left_next;
    logic [15:0] answers_left_reg, answers_left_next;
    logic [15:0] skip_count_reg, skip_count_next;
    logic [15:0] record_type_reg, record_type_next;
    logic [15:0] rdata_length_reg, rdata_length_next;
    logic [31:0] address_accum_reg, address_accum_next;
    logic        found_flag_reg, found_flag_next;
    logic [2:0]  error_code_reg, error_code_next;

    logic        is_a;
    logic [15:0] skip_dec;
    logic [15:0] ans_dec;

    assign is_a     = (record_type_reg == drp_pkg::A_TYPE) && (rdata_length_reg == drp_pkg::A_LEN);
    assign skip_dec = skip_count_reg - 16'd1;
    assign ans_dec  = answers_left_reg - 16'd1;
    assign res_fire = consume & item.last;

    // next state of the walk for the byte in the input register
    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] hw;
        b                   = item.data;
        hw                  = {header_word_reg[7:0], b};
        phase_next          = phase_reg;
        byte_index_next     = byte_index_reg;
        header_word_next    = header_word_reg;
        questions_left_next = questions_left_reg;
        answers_left_next   = answers_left_reg;
        skip_count_next     = skip_count_reg;
        record_type_next    = record_type_reg;
        rdata_length_next   = rdata_length_reg;
        address_accum_next  = address_accum_reg;
        found_flag_next     = found_flag_reg;
        error_code_next     = error_code_reg;

        unique case (phase_reg)
            drp_pkg::PH_HEADER:
            begin
                header_word_next = hw;
                if (byte_index_reg == 4'd1)
                begin
                    if (hw != expected_id && error_code_reg == drp_pkg::ST_OK)
                        error_code_next = drp_pkg::ST_ID_MISMATCH;
                end
                else if (byte_index_reg == 4'd3)
                begin
                    if (error_code_reg == drp_pkg::ST_OK)
                    begin
                        if (!hw[15])
                            error_code_next = drp_pkg::ST_NOT_RESPONSE;
                        else if (hw[3:0] != 4'd0)
                            error_code_next = drp_pkg::ST_RCODE;
                    end
                end
                else if (byte_index_reg == 4'd5)
                begin
                    questions_left_next = hw;
                end
                else if (byte_index_reg == 4'd7)
                begin
                    answers_left_next = hw;
                    if (hw == 16'd0 && error_code_reg == drp_pkg::ST_OK)
                        error_code_next = drp_pkg::ST_NO_ANSWERS;
                end
                if (byte_index_reg == 4'(drp_pkg::HEADER_LAST_IDX))
                begin
                    byte_index_next = 4'd0;
                    phase_next = (error_code_next != drp_pkg::ST_OK) ?
                                 drp_pkg::PH_HALT : drp_pkg::PH_NAME;
                end
                else
                begin
                    byte_index_next = byte_index_reg + 4'd1;
                end
            end
            drp_pkg::PH_NAME, drp_pkg::PH_PTR:
            begin
                if (phase_reg == drp_pkg::PH_NAME && b != 8'd0)
                begin
                    if ((b & drp_pkg::PTR_MASK) == drp_pkg::PTR_MASK)
                    begin
                        phase_next = drp_pkg::PH_PTR;
                    end
                    else
                    begin
                        skip_count_next = {8'd0, b};
                        phase_next = drp_pkg::PH_LABEL;
                    end
                end
                else if (questions_left_reg != 16'd0)
                begin
                    // name finished: question fixed part or answer fixed part
                    phase_next = drp_pkg::PH_QFIXED;
                    skip_count_next = 16'(drp_pkg::QUESTION_FIXED_BYTES);
                end
                else
                begin
                    phase_next = drp_pkg::PH_AFIXED;
                    byte_index_next = 4'd0;
                end
            end
            drp_pkg::PH_LABEL:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = drp_pkg::PH_NAME;
            end
            drp_pkg::PH_QFIXED:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    questions_left_next = questions_left_reg - 16'd1;
                    phase_next = drp_pkg::PH_NAME;
                end
            end
            drp_pkg::PH_AFIXED:
            begin
                if (byte_index_reg < 4'd2)
                    record_type_next = {record_type_reg[7:0], b};
                else if (byte_index_reg >= 4'd8)
                    rdata_length_next = {rdata_length_reg[7:0], b};
                if (byte_index_reg >= 4'(drp_pkg::ANSWER_FIXED_BYTES - 1))
                begin
                    byte_index_next = 4'd0;
                    address_accum_next = 32'd0;
                    skip_count_next = rdata_length_next;
                    if (rdata_length_next == 16'd0)
                    begin
                        answers_left_next = ans_dec;
                        phase_next = (ans_dec == 16'd0) ? drp_pkg::PH_DONE : drp_pkg::PH_NAME;
                    end
                    else
                    begin
                        phase_next = drp_pkg::PH_RDATA;
                    end
                end
                else
                begin
                    byte_index_next = byte_index_reg + 4'd1;
                end
            end
            drp_pkg::PH_RDATA:
            begin
                if (is_a)
                    address_accum_next = {address_accum_reg[23:0], b};
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (is_a)
                    begin
                        found_flag_next = 1'b1;
                        phase_next = drp_pkg::PH_HALT;
                    end
                    else
                    begin
                        record_type_next = 16'd0;
                        rdata_length_next = 16'd0;
                        answers_left_next = ans_dec;
                        phase_next = (ans_dec == 16'd0) ? drp_pkg::PH_DONE : drp_pkg::PH_NAME;
                    end
                end
            end
            drp_pkg::PH_DONE, drp_pkg::PH_HALT:
            begin
                // drop bytes until the message ends
            end
            default:
            begin
            end
        endcase
    end

    // result of the message as it stands after this byte
    always_comb
    begin
        result.ip = 32'd0;
        unique case (phase_next)
            drp_pkg::PH_HEADER:
                result.status = drp_pkg::ST_SHORT;
            drp_pkg::PH_HALT:
                result.status = found_flag_next ? drp_pkg::ST_OK : error_code_next;
            drp_pkg::PH_DONE:
                result.status = drp_pkg::ST_NO_A;
            default:
                result.status = drp_pkg::ST_TRUNCATED;
        endcase
        if (result.status == drp_pkg::ST_OK)
            result.ip = address_accum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= drp_pkg::PH_HEADER;
            byte_index_reg     <= 4'd0;
            header_word_reg    <= 16'd0;
            questions_left_reg <= 16'd0;
            answers_left_reg   <= 16'd0;
            skip_count_reg     <= 16'd0;
            record_type_reg    <= 16'd0;
            rdata_length_reg   <= 16'd0;
            address_accum_reg  <= 32'd0;
            found_flag_reg     <= 1'b0;
            error_code_reg     <= 3'd0;
        end
        else if (res_fire)
        begin
            // message ended: start over for the next one
            phase_reg          <= drp_pkg::PH_HEADER;
            byte_index_reg     <= 4'd0;
            header_word_reg    <= 16'd0;
            questions_left_reg <= 16'd0;
            answers_left_reg   <= 16'd0;
            skip_count_reg     <= 16'd0;
            record_type_reg    <= 16'd0;
            rdata_length_reg   <= 16'd0;
            address_accum_reg  <= 32'd0;
            found_flag_reg     <= 1'b0;
            error_code_reg     <= 3'd0;
        end
        else if (consume)
        begin
            phase_reg          <= phase_next;
            byte_index_reg     <= byte_index_next;
            header_word_reg    <= header_word_next;
            questions_left_reg <= questions_left_next;
            answers_left_reg   <= answers_left_next;
            skip_count_reg     <= skip_count_next;
            record_type_reg    <= record_type_next;
            rdata_length_reg   <= rdata_length_next;
            address_accum_reg  <= address_accum_next;
            found_flag_reg     <= found_flag_next;
            error_code_reg     <= error_code_next;
        end
    end

endmodule

FILE: rtl/core/drp_out_stage.sv
// Result register: holds one parse result until the consumer takes it.
module drp_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  drp_pkg::result_t result,
    output logic             out_room,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [31:0]      ip_address
);

    logic             vld_reg;
    logic             vld_next;
    drp_pkg::result_t res_reg;

    assign out_room   = ~vld_reg | ~out_stall;
    assign vld_next   = load | (vld_reg & out_stall);
    assign out_valid  = vld_reg;
    assign status     = res_reg.status;
    assign ip_address = res_reg.ip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

FILE: rtl/core/dns_a_record_response_parser.sv
// Top level of the DNS A-record response parser.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  data_byte[7:0], last_byte
//   out       output     out_valid/out_stall  status[2:0], ip_address[31:0]
//   cfg       input      cfg_wr_en            cfg_wr_data[15:0] (expected id)
//
// One byte per cycle sustained while no result is stalled at the output. A byte
// waits in the input register and is parsed on its way into the state registers;
// a final byte loads the result register, and that load raises out_valid.
// in_stall rises only when the input register holds a final byte while a
// previous result is still stalled at the output. Reset clears the parse state,
// the expected id and both valid flags at once; no sweep is needed.
module dns_a_record_response_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] ip_address,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic [15:0]       expected_id_reg;
    logic              out_room;
    logic              consume;
    logic              res_fire;
    drp_pkg::in_item_t item;
    drp_pkg::result_t  result;

    // hold the transaction id of the outstanding query
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            expected_id_reg <= cfg_wr_data;
        end
    end

    // stage 1: capture the incoming byte, advance when the result side allows
    drp_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_room  (out_room),
        .consume   (consume),
        .item      (item)
    );

    // stage 2: walk the message and form the result on its last byte
    drp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .expected_id (expected_id_reg),
        .consume     (consume),
        .item        (item),
        .res_fire    (res_fire),
        .result      (result)
    );

    // result register toward the consumer
    drp_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_fire),
        .result     (result),
        .out_room   (out_room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .ip_address (ip_address)
    );

endmodule

FILE: rtl/core/drp_checker.sv
// Port-level checks of the DNS A-record response parser, bound to the top level.
module drp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [31:0] ip_address,
    input logic        cfg_wr_en,
    input logic [15:0] cfg_wr_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(ip_address))
        else $error("result changed while stalled");

    // the address is zero on every failing status
    a_ip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != drp_pkg::ST_OK |-> ip_address == 32'd0)
        else $error("address nonzero on failing status");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result side");

    // a new result comes from a byte consumed without stall
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("result appeared while input was stalled");

endmodule

bind dns_a_record_response_parser drp_checker u_drp_checker (.*);
